// ===== hw/rtl/bfp_pkg.sv =====
package bfp_pkg;

   // Field limits of the packer.
   localparam int MAX_FIELD_BITS = 32;
   localparam int FIELD_LIMIT    = (MAX_FIELD_BITS < 32) ? MAX_FIELD_BITS : 32;

   // Widths of the item fields and of the internal datapath.
   localparam int VALUE_W = 32;
   localparam int WIDTH_W = 6;
   localparam int BYTE_W  = 8;
   localparam int HAVE_W  = 3;
   localparam int ACC_W   = 40;
   localparam int CNT_W   = 6;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_BIT_ORDER = 1'b0;

   // Item kinds carried on tuser.
   localparam logic MODE_APPEND = 1'b0;
   localparam logic MODE_ALIGN  = 1'b1;

   // Bit order codes.
   localparam logic ORDER_MSB = 1'b0;
   localparam logic ORDER_LSB = 1'b1;

   // Mask of the low n bits of a field value; n at or above the field width gives all ones.
   function automatic logic [VALUE_W-1:0] field_mask(input logic [WIDTH_W-1:0] n);
      logic [VALUE_W:0] m;
      m = ({{VALUE_W{1'b0}}, 1'b1} << n) - {{VALUE_W{1'b0}}, 1'b1};
      return m[VALUE_W-1:0];
   endfunction

   // Mask of the low n bits of a byte.
   function automatic logic [BYTE_W-1:0] byte_mask(input logic [CNT_W-1:0] n);
      logic [BYTE_W:0] m;
      m = ({{BYTE_W{1'b0}}, 1'b1} << n) - {{BYTE_W{1'b0}}, 1'b1};
      return m[BYTE_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/bit_field_packer_core.sv =====
// Variable-length bit packer.
// Input words arrive on req_*: tuser selects append (0) or align (1), tdata
// carries the field value and the number of bits to append (widths above 32
// count as 32). Packed bytes leave on rsp_*, one byte per word, with tlast on
// the final byte of an input word. A word that completes no byte produces nothing.
// The bit order (most or least significant bit first) is set through the
// csr_* register port and should only change while the block is idle.
// Operation: an accepted word that completes a byte loads the accumulator; the
// shared byte shifter then extracts the completed bytes one at a time, at most
// four per word, waiting while the output register holds an untaken byte.
// req_tready is high only while no byte extraction is in progress.
// The output register holds a byte while rsp_tready is low; extraction and
// req_tready wait for it, while an idle block may still take a new word.
// Reset clears the pending bits, the bit order (most significant first) and
// the output valid flag.
module bit_field_packer_core (
   input  logic                           clock,
   input  logic                           reset,
   // tuser: mode
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata: field_value [31:0], field_width [37:32], zero [39:38]
   input  logic [39:0]                    req_tdata,
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata: out_byte [7:0]
   output logic [7:0]                     rsp_tdata,
   output logic                           rsp_tlast,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bfp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bfp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bfp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import bfp_pkg::*;

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_RUN  = 1'b1;

   logic                 state_ff, state_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic                 order_ff, order_in;
   logic [BYTE_W-1:0]    pending_ff, pending_in;
   logic [HAVE_W-1:0]    have_ff, have_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]    rsp_byte_ff, rsp_byte_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 bit_order;
   logic                 req_fire;
   logic                 out_free;
   logic                 emit;
   logic [VALUE_W-1:0]   field_value;
   logic [WIDTH_W-1:0]   field_width;
   logic [WIDTH_W-1:0]   width_sat;
   logic [VALUE_W-1:0]   value_m;
   logic [BYTE_W-1:0]    pend_m;
   logic [3:0]           free_cnt;
   logic [BYTE_W-1:0]    align_byte;
   logic [ACC_W-1:0]     acc_load;
   logic [CNT_W-1:0]     total_load;
   logic [CNT_W-1:0]     total_next;
   logic [ACC_W-1:0]     acc_next;
   logic [CNT_W-1:0]     shift_off;
   logic [BYTE_W-1:0]    shift_byte;

   // Configuration registers.
   bfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .bit_order   (bit_order)
   );

   // Shared byte extraction unit.
   bfp_byte_shifter u_shifter (
      .acc      (acc_ff),
      .offset   (shift_off),
      .byte_out (shift_byte)
   );

   assign req_tready  = (state_ff == STATE_IDLE);
   assign req_fire    = req_tvalid & req_tready;
   assign out_free    = ~rsp_valid_ff | rsp_tready;
   assign emit        = (state_ff == STATE_RUN) & out_free;
   assign field_value = req_tdata[VALUE_W-1:0];
   assign field_width = req_tdata[VALUE_W+WIDTH_W-1:VALUE_W];

   // Accumulator load for a new word.
   always_comb begin
      width_sat  = (field_width > WIDTH_W'(FIELD_LIMIT)) ? WIDTH_W'(FIELD_LIMIT) : field_width;
      value_m    = field_value & field_mask(width_sat);
      pend_m     = pending_ff & byte_mask({{(CNT_W-HAVE_W){1'b0}}, have_ff});
      free_cnt   = 4'd8 - {1'b0, have_ff};
      align_byte = (bit_order == ORDER_MSB) ? (pend_m << free_cnt) : pend_m;
      if (req_tuser == MODE_ALIGN) begin
         acc_load   = {{(ACC_W-BYTE_W){1'b0}}, align_byte};
         total_load = (have_ff != '0) ? CNT_W'(BYTE_W) : '0;
      end else begin
         if (bit_order == ORDER_MSB) begin
            acc_load = ({{(ACC_W-BYTE_W){1'b0}}, pend_m} << width_sat)
                     | {{(ACC_W-VALUE_W){1'b0}}, value_m};
         end else begin
            acc_load = {{(ACC_W-BYTE_W){1'b0}}, pend_m}
                     | ({{(ACC_W-VALUE_W){1'b0}}, value_m} << have_ff);
         end
         total_load = {{(CNT_W-HAVE_W){1'b0}}, have_ff} + width_sat;
      end
   end

   // One byte per step: most significant first reads below the top bit,
   // least significant first reads the bottom byte and shifts it out.
   always_comb begin
      total_next = total_ff - CNT_W'(BYTE_W);
      shift_off  = (order_ff == ORDER_MSB) ? total_next : '0;
      acc_next   = (order_ff == ORDER_MSB) ? acc_ff : (acc_ff >> BYTE_W);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      total_in     = total_ff;
      order_in     = order_ff;
      pending_in   = pending_ff;
      have_in      = have_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (req_fire) begin
         if (total_load >= CNT_W'(BYTE_W)) begin
            state_in = STATE_RUN;
            acc_in   = acc_load;
            total_in = total_load;
            order_in = bit_order;
         end else begin
            pending_in = acc_load[BYTE_W-1:0] & byte_mask(total_load);
            have_in    = total_load[HAVE_W-1:0];
         end
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = shift_byte;
         rsp_last_in  = (total_next < CNT_W'(BYTE_W));
         acc_in       = acc_next;
         total_in     = total_next;
         if (total_next < CNT_W'(BYTE_W)) begin
            state_in   = STATE_IDLE;
            pending_in = acc_next[BYTE_W-1:0] & byte_mask(total_next);
            have_in    = total_next[HAVE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         total_ff     <= '0;
         order_ff     <= ORDER_MSB;
         pending_ff   <= '0;
         have_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         order_ff     <= order_in;
         pending_ff   <= pending_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Extraction only runs with at least one whole byte in the accumulator.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_RUN) |-> (total_ff >= CNT_W'(BYTE_W)))
      else $error("byte extraction with fewer than eight bits left");

   // The final byte of a word returns the sequencer to idle.
   assert property (@(posedge clock) disable iff (reset)
      (emit && rsp_last_in) |=> (state_ff == STATE_IDLE))
      else $error("sequencer did not return to idle after the final byte");

   // A held output byte stays valid and unchanged while rsp_tready is low.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast)))
      else $error("held output byte was overwritten");

   // A non-final byte is always followed by further extraction.
   assert property (@(posedge clock) disable iff (reset)
      (emit && !rsp_last_in) |=> (state_ff == STATE_RUN))
      else $error("word ended without a final byte");

endmodule

// ===== hw/rtl/bfp_byte_shifter.sv =====
module bfp_byte_shifter (
   input  logic [bfp_pkg::ACC_W-1:0]  acc,
   input  logic [bfp_pkg::CNT_W-1:0]  offset,
   output logic [bfp_pkg::BYTE_W-1:0] byte_out
);
   import bfp_pkg::*;

   logic [ACC_W-1:0] shifted;

   // Shared right shifter that picks one byte out of the accumulator.
   always_comb begin
      shifted  = acc >> offset;
      byte_out = shifted[BYTE_W-1:0];
   end

endmodule

// ===== hw/rtl/bfp_csr.sv =====
module bfp_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bfp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bfp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bfp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output logic                           bit_order
);
   import bfp_pkg::*;

   logic bit_order_ff;
   logic bit_order_in;
   logic wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register write decode; the word index is the address divided by four.
   always_comb begin
      bit_order_in = bit_order_ff;
      if (wr_en && (csr_paddr[2] == REG_BIT_ORDER)) begin
         bit_order_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_order_ff <= ORDER_MSB;
      end else begin
         bit_order_ff <= bit_order_in;
      end
   end

   // Read back.
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_BIT_ORDER) begin
         csr_prdata = {{(CSR_DATA_W-1){1'b0}}, bit_order_ff};
      end
   end

   assign bit_order = bit_order_ff;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import bfp_pkg::*;

   // One input word: append a field or align to the next byte boundary.
   typedef struct {
      logic                 mode;
      logic [VALUE_W-1:0]   value;
      logic [WIDTH_W-1:0]   width;
   } field_word_type;

   // One output word: a packed byte and its end-of-item flag.
   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              last;
   } packed_byte_type;

   // Receiver stall patterns.
   typedef enum int {RX_STEADY, RX_RANDOM, RX_SPARSE} rx_pattern_type;

   logic                  clock;
   logic                  reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [39:0]           req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Words waiting to be sent, and bytes the packer still owes us.
   field_word_type  field_words[$];
   packed_byte_type packed_due[$];

   // Shadow state of the packer.
   logic         order_q = ORDER_MSB;
   logic [7:0]   held_bits = '0;
   int           open_slots = 8;

   int              errors = 0;
   int              burst_left = 0;
   int              gap_left = 0;
   int              pattern_left = 0;
   rx_pattern_type  rx_pattern = RX_STEADY;
   bit              hold_off = 1'b0;
   packed_byte_type due;
   field_word_type  next_word;

   bit_field_packer_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),     // field_value [31:0], field_width [37:32], zero [39:38]
      .req_tuser   (req_tuser),     // mode
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),     // out_byte [7:0]
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Work out the bytes that one accepted word must produce and update the shadow state.
   function automatic void pack_word(input logic mode, input logic [31:0] value,
                                     input logic [5:0] width);
      logic [39:0] acc;
      logic [31:0] bits;
      logic [7:0]  made[4];
      int          have;
      int          total;
      int          w;
      int          cnt;
      cnt = 0;
      have = 8 - open_slots;
      held_bits &= 8'((9'd1 << have) - 1);
      if (mode == MODE_ALIGN) begin
         // A partial byte goes out padded with zeros.
         if (have != 0) begin
            made[0] = (order_q == ORDER_MSB) ? 8'(held_bits << open_slots) : held_bits;
            cnt = 1;
         end
         held_bits = '0;
         open_slots = 8;
      end else begin
         w = (int'(width) > FIELD_LIMIT) ? FIELD_LIMIT : int'(width);
         bits = value & 32'((64'd1 << w) - 1);
         total = have + w;
         if (order_q == ORDER_MSB) begin
            // Oldest bits sit at the top of the accumulator.
            acc = (40'(held_bits) << w) | 40'(bits);
            while (total >= 8) begin
               total -= 8;
               made[cnt] = 8'(acc >> total);
               cnt++;
               acc &= (40'd1 << total) - 1;
            end
         end else begin
            // Oldest bits sit at the bottom of the accumulator.
            acc = 40'(held_bits) | (40'(bits) << have);
            while (total >= 8) begin
               made[cnt] = acc[7:0];
               cnt++;
               acc >>= 8;
               total -= 8;
            end
         end
         held_bits = acc[7:0] & 8'((9'd1 << total) - 1);
         open_slots = 8 - total;
      end
      for (int i = 0; i < cnt; i++) begin
         packed_due.push_back('{data: made[i], last: (i == cnt - 1)});
      end
   endfunction

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = $urandom_range(1, 16);
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            pack_word(req_tuser, req_tdata[31:0], req_tdata[37:32]);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (field_words.size() != 0) begin
               next_word = field_words.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= next_word.mode;
               req_tdata <= {2'b00, next_word.width, next_word.value};
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                           : $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25)
                                                         : $urandom_range(0, 5);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each byte against the oldest expectation, stall on its own pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (packed_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, expected none, actual byte %h last %b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               due = packed_due.pop_front();
               if (rsp_tdata !== due.data) begin
                  errors++;
                  $display("%0t: out_byte mismatch, expected %h, actual %h",
                           $time, due.data, rsp_tdata);
               end
               if (rsp_tlast !== due.last) begin
                  errors++;
                  $display("%0t: last mismatch, expected %b, actual %b",
                           $time, due.last, rsp_tlast);
               end
            end
         end
         if (pattern_left == 0) begin
            rx_pattern = rx_pattern_type'($urandom_range(0, 2));
            pattern_left = $urandom_range(8, 64);
         end else begin
            pattern_left--;
         end
         case (rx_pattern)
            RX_STEADY: rsp_tready <= !hold_off;
            RX_RANDOM: rsp_tready <= !hold_off && ($urandom_range(0, 1) == 1);
            default:   rsp_tready <= !hold_off && ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // One long receiver hold-off while a large batch of words is waiting to go in.
   initial begin
      do @(negedge clock); while (field_words.size() < 40);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Wait until every word is sent and every byte is back, then let the core settle.
   task automatic wait_drained();
      while (field_words.size() != 0 || req_tvalid || packed_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
   endtask

   // Write the bit order register, read it back and update the shadow copy.
   task automatic set_order(input logic order);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'(4 * REG_BIT_ORDER);
      csr_pwdata <= CSR_DATA_W'(order);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      order_q = order;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(order)) begin
         errors++;
         $display("%0t: bit_order readback mismatch, expected %h, actual %h",
                  $time, CSR_DATA_W'(order), csr_prdata);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Field extremes, masking, saturation, empty and partial aligns.
   task automatic add_directed();
      field_words.push_back('{MODE_ALIGN,  32'hFFFF_FFFF, 6'd63});
      field_words.push_back('{MODE_APPEND, 32'hFFFF_FFFF, 6'd0});
      field_words.push_back('{MODE_APPEND, 32'h0000_001D, 6'd3});
      field_words.push_back('{MODE_APPEND, 32'hA5C3_0F81, 6'd32});
      field_words.push_back('{MODE_APPEND, 32'h1234_5678, 6'd63});
      field_words.push_back('{MODE_APPEND, 32'hFFFF_FFFF, 6'd33});
      field_words.push_back('{MODE_APPEND, 32'hFFFF_FFFF, 6'd5});
      field_words.push_back('{MODE_ALIGN,  32'h0000_0000, 6'd0});
      field_words.push_back('{MODE_APPEND, 32'h0000_0000, 6'd8});
      field_words.push_back('{MODE_APPEND, 32'h0000_0001, 6'd1});
      field_words.push_back('{MODE_APPEND, 32'h0000_007F, 6'd7});
      // Leaves bits pending so the next order change happens mid-byte.
      field_words.push_back('{MODE_APPEND, 32'h0000_0002, 6'd2});
   endtask

   // Random words: mostly appends of random width, with some aligns and oversize widths.
   task automatic add_random(input int count);
      field_word_type f;
      repeat (count) begin
         f.mode = ($urandom_range(0, 7) == 0) ? MODE_ALIGN : MODE_APPEND;
         case ($urandom_range(0, 9))
            0:       f.width = 6'($urandom_range(33, 63));
            1:       f.width = 6'd0;
            2:       f.width = 6'd32;
            default: f.width = 6'($urandom_range(1, 31));
         endcase
         case ($urandom_range(0, 7))
            0:       f.value = '0;
            1:       f.value = '1;
            default: f.value = $urandom;
         endcase
         field_words.push_back(f);
      end
   endtask

   // Main sequence: reset, directed words in both orders, then random phases.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      set_order(ORDER_MSB);
      add_directed();
      wait_drained();
      set_order(ORDER_LSB);
      add_directed();
      wait_drained();
      set_order(ORDER_MSB);
      add_random(70);
      wait_drained();
      set_order(ORDER_LSB);
      add_random(70);
      wait_drained();
      set_order(ORDER_LSB);
      add_random(70);
      wait_drained();
      set_order(ORDER_MSB);
      add_random(70);
      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // Timeout.
   initial begin
      #2000000;
      $display("tb: FAIL");
      $finish;
   end

endmodule
